@@ design/fopw_pkg.sv @@
// ----------------------------------------------------------------------------
// fopw_pkg: shared types and constants for the four-level page walker
// Field widths, request/result codes, entry bit positions and the result
// record passed between the walker core and its output buffer.
// ----------------------------------------------------------------------------
package fopw_pkg;

  localparam int VA_W      = 48;
  localparam int PA_W      = 52;
  localparam int ENTRY_W   = 64;
  localparam int IDX_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = PA_W;

  // Entry bits
  localparam int BIT_PRESENT = 0;
  localparam int BIT_PS      = 7;

  // Request commands
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_RESPONSE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_PADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_VALID = 1'b1;

  // Walk levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PAGE_4K = 2'd0,
    PAGE_2M = 2'd1,
    PAGE_1G = 2'd2
  } page_t;

  typedef enum logic [1:0] {
    FAULT_NO_ROOT     = 2'd0,
    FAULT_READ_FAILED = 2'd1,
    FAULT_NOT_PRESENT = 2'd2
  } fault_t;

  typedef struct packed {
    kind_t            kind;
    logic [PA_W-1:0]  read_addr;
    logic [PA_W-1:0]  phys_addr;
    page_t            size_class;
    fault_t           fault_code;
    logic [1:0]       fault_level;
  } result_t;

  // Table index of a virtual address at a walk level
  function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    unique case (level)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

@@ design/fopw_req_if.sv @@
// ----------------------------------------------------------------------------
// fopw_req_if: request channel of the page walker
// Carries translate requests and memory read responses.
// ----------------------------------------------------------------------------
interface fopw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [fopw_pkg::VA_W-1:0]     virt_addr;
  logic [fopw_pkg::ENTRY_W-1:0]  entry_data;
  logic                          read_ok;

  modport source (output valid, command, virt_addr, entry_data, read_ok, input ready);
  modport sink   (input valid, command, virt_addr, entry_data, read_ok, output ready);
endinterface

@@ design/fopw_res_if.sv @@
// ----------------------------------------------------------------------------
// fopw_res_if: result channel of the page walker
// Carries memory read requests, finished translations and faults.
// ----------------------------------------------------------------------------
interface fopw_res_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [fopw_pkg::PA_W-1:0]  read_addr;
  logic [fopw_pkg::PA_W-1:0]  phys_addr;
  logic [1:0]                 size_class;
  logic [1:0]                 fault_code;
  logic [1:0]                 fault_level;

  modport source (output valid, kind, read_addr, phys_addr, size_class, fault_code,
                  fault_level, input ready);
  modport sink   (input valid, kind, read_addr, phys_addr, size_class, fault_code,
                  fault_level, output ready);
endinterface

@@ design/fopw_core.sv @@
// ----------------------------------------------------------------------------
// fopw_core: walk state and single-pass step logic
// Holds busy, level and saved address; turns one accepted request into at
// most one result in the same cycle.
// ----------------------------------------------------------------------------
module fopw_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          command,
  input  logic [fopw_pkg::VA_W-1:0]     virt_addr,
  input  logic [fopw_pkg::ENTRY_W-1:0]  entry_data,
  input  logic                          read_ok,
  input  logic [fopw_pkg::PA_W-1:0]     root_paddr,
  input  logic                          root_valid,
  output logic                          res_valid,
  output fopw_pkg::result_t             res
);

  logic                       busy, busy_next;
  logic [1:0]                 walk_level, walk_level_next;
  logic [fopw_pkg::VA_W-1:0]  saved_vaddr, saved_vaddr_next;
  logic [1:0]                 level_up;
  logic [fopw_pkg::IDX_W-1:0] root_idx, next_idx;

  assign level_up = walk_level + 2'd1;
  assign root_idx = fopw_pkg::table_index(virt_addr, fopw_pkg::LVL_PML4);
  assign next_idx = fopw_pkg::table_index(saved_vaddr, level_up);

  always_comb begin
    busy_next        = busy;
    walk_level_next  = walk_level;
    saved_vaddr_next = saved_vaddr;
    res_valid        = 1'b0;
    res              = '0;
    if (accept) begin
      if (command == fopw_pkg::CMD_TRANSLATE) begin
        busy_next       = 1'b0;
        walk_level_next = fopw_pkg::LVL_PML4;
        res_valid       = 1'b1;
        if (!root_valid) begin
          res.kind        = fopw_pkg::KIND_FAULT;
          res.fault_code  = fopw_pkg::FAULT_NO_ROOT;
          res.fault_level = fopw_pkg::LVL_PML4;
        end else begin
          busy_next        = 1'b1;
          saved_vaddr_next = virt_addr;
          res.kind         = fopw_pkg::KIND_READ;
          res.read_addr    = root_paddr + fopw_pkg::PA_W'({root_idx, 3'b000});
        end
      end else if (busy) begin
        res_valid       = 1'b1;
        busy_next       = 1'b0;
        walk_level_next = fopw_pkg::LVL_PML4;
        priority if (!read_ok) begin
          res.kind        = fopw_pkg::KIND_FAULT;
          res.fault_code  = fopw_pkg::FAULT_READ_FAILED;
          res.fault_level = walk_level;
        end else if (!entry_data[fopw_pkg::BIT_PRESENT]) begin
          res.kind        = fopw_pkg::KIND_FAULT;
          res.fault_code  = fopw_pkg::FAULT_NOT_PRESENT;
          res.fault_level = walk_level;
        end else if (walk_level == fopw_pkg::LVL_PDPT && entry_data[fopw_pkg::BIT_PS]) begin
          res.kind       = fopw_pkg::KIND_DONE;
          res.size_class = fopw_pkg::PAGE_1G;
          res.phys_addr  = {entry_data[51:30], saved_vaddr[29:0]};
        end else if (walk_level == fopw_pkg::LVL_PD && entry_data[fopw_pkg::BIT_PS]) begin
          res.kind       = fopw_pkg::KIND_DONE;
          res.size_class = fopw_pkg::PAGE_2M;
          res.phys_addr  = {entry_data[51:21], saved_vaddr[20:0]};
        end else if (walk_level == fopw_pkg::LVL_PT) begin
          res.kind       = fopw_pkg::KIND_DONE;
          res.size_class = fopw_pkg::PAGE_4K;
          res.phys_addr  = {entry_data[51:12], saved_vaddr[11:0]};
        end else begin
          // frame is 4 KiB aligned, so frame + index*8 is a plain concatenation
          busy_next       = 1'b1;
          walk_level_next = level_up;
          res.kind        = fopw_pkg::KIND_READ;
          res.read_addr   = {entry_data[51:12], next_idx, 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      walk_level  <= fopw_pkg::LVL_PML4;
      saved_vaddr <= '0;
    end else begin
      busy        <= busy_next;
      walk_level  <= walk_level_next;
      saved_vaddr <= saved_vaddr_next;
    end
  end

  a_read_keeps_walk: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == fopw_pkg::KIND_READ |=> busy)
    else $error("read request issued but walk not active");

  a_end_stops_walk: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == fopw_pkg::KIND_DONE || res.kind == fopw_pkg::KIND_FAULT)
    |=> !busy)
    else $error("walk still active after done or fault");

  a_idle_response_silent: assert property (@(posedge clk) disable iff (rst)
    accept && command == fopw_pkg::CMD_RESPONSE && !busy |-> !res_valid)
    else $error("response while idle produced a result");

endmodule

@@ design/fopw_skid.sv @@
// ----------------------------------------------------------------------------
// fopw_skid: two-entry result buffer
// Output register plus one skid stage; space is a registered flag.
// ----------------------------------------------------------------------------
module fopw_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  fopw_pkg::result_t  push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output fopw_pkg::result_t  out_data
);

  logic              skid_valid;
  fopw_pkg::result_t skid_data;
  logic              out_fire;

  assign out_fire = out_valid && out_ready;
  assign space    = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && push))
    else $error("skid stage filled without a stalled output");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

endmodule

@@ design/four_level_page_walker.sv @@
// ----------------------------------------------------------------------------
// four_level_page_walker: x86-64 four-level page table walker
// Translates 48-bit virtual addresses by asking for page table entries one
// level at a time and reporting the final physical address or a fault.
// ----------------------------------------------------------------------------
// Usage: send a translate request (command 0) with the virtual address; the
// walker answers with a read request for the top-level entry at root + idx*8.
// Feed each memory response back as command 1 with the entry and read_ok.
// The walker answers every response with either the next read request, a
// done result (4 KiB, 2 MiB or 1 GiB page), or a fault (no root, read failed,
// entry not present) with the level it happened at. A new translate request
// drops any walk in progress; a response while idle is dropped silently.
// Rate: one request per cycle unless stalled. Each is handled in one pass of
// logic (one 52-bit add for the root lookup, otherwise bit selects); its
// result goes to the output register, or to the skid stage if that stalls.
// Requests stall only when both hold unaccepted results. The user must
// write configuration (root address, root valid) through cfg_we/cfg_idx/
// cfg_data only while the walker is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module four_level_page_walker (
  input  logic                                 clk,
  input  logic                                 rst,
  fopw_req_if.sink                             req,
  fopw_res_if.source                           res,
  input  logic                                 cfg_we,
  input  logic [fopw_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [fopw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [fopw_pkg::PA_W-1:0] root_paddr;
  logic                      root_valid;

  // Request handshake and step result
  logic              req_fire;
  logic              space;
  logic              step_valid;
  fopw_pkg::result_t step_res;
  fopw_pkg::result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_paddr <= '0;
      root_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fopw_pkg::REG_ROOT_PADDR: root_paddr <= cfg_data;
        fopw_pkg::REG_ROOT_VALID: root_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Ready depends only on the skid stage, never on the result side's ready.
  assign req.ready = space;
  assign req_fire  = req.valid && space;

  fopw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (req_fire),
    .command    (req.command),
    .virt_addr  (req.virt_addr),
    .entry_data (req.entry_data),
    .read_ok    (req.read_ok),
    .root_paddr (root_paddr),
    .root_valid (root_valid),
    .res_valid  (step_valid),
    .res        (step_res)
  );

  fopw_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (step_valid),
    .push_data (step_res),
    .space     (space),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  assign res.kind        = out_data.kind;
  assign res.read_addr   = out_data.read_addr;
  assign res.phys_addr   = out_data.phys_addr;
  assign res.size_class  = out_data.size_class;
  assign res.fault_code  = out_data.fault_code;
  assign res.fault_level = out_data.fault_level;

endmodule
